>>> src/assert_macros.svh
// Assertion macros shared by the 3x3 blur RTL.
// Each use expands to one labeled concurrent assertion on clk, disabled in rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define G3F_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define G3F_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/g3f_pkg.sv
// Shared types and constants of the 3x3 RGBA blur.
// No dependencies; every module file imports it.
package g3f_pkg;

  localparam int CHAN_N = 4;   // red, green, blue, alpha
  localparam int CH_W   = 8;
  localparam int POS_W  = 11;  // row/column tag width
  localparam int SIZE_W = 12;  // image_width / image_height registers
  localparam int WGT_W  = 16;  // unsigned Q0.16 weights
  localparam int CFG_W  = 16;  // config write data
  localparam int IDX_W  = 3;   // config register index

  // Config register indexes
  localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_CORNER_WEIGHT = 3'd2;
  localparam logic [IDX_W-1:0] CFG_EDGE_WEIGHT   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_CENTER_WEIGHT = 3'd4;

  // Reset values
  localparam logic [SIZE_W-1:0] RST_WIDTH  = 12'd640;
  localparam logic [SIZE_W-1:0] RST_HEIGHT = 12'd480;
  localparam logic [WGT_W-1:0]  RST_CORNER = 16'd4922;
  localparam logic [WGT_W-1:0]  RST_EDGE   = 16'd8113;
  localparam logic [WGT_W-1:0]  RST_CENTER = 16'd13382;

  // Channel k sits at bits 8k+7:8k (red lowest)
  typedef logic [CHAN_N-1:0][CH_W-1:0] pixel_t;

  // One window column, top row first
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } col_t;

  // One line store entry: row above and the row above that
  typedef struct packed {
    pixel_t above;
    pixel_t above2;
  } line_entry_t;

  typedef struct packed {
    logic [WGT_W-1:0] corner_wgt;
    logic [WGT_W-1:0] edge_wgt;
    logic [WGT_W-1:0] center_wgt;
  } weights_t;

  // Position tags that travel with an item
  typedef struct packed {
    logic             res;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } tag_t;

endpackage

>>> src/g3f_line_store.sv
// Dual line store of the blur: one entry per column holding two rows of pixels.
// Uses g3f_pkg; one write and one registered read per cycle.
module g3f_line_store
  import g3f_pkg::*;
#(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output line_entry_t       rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  line_entry_t       wr_data
);

  line_entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/g3f_col_cell.sv
// One column cell of the 3x3 window: holds three pixels, passes them left on shift.
// Uses g3f_pkg; also gives per-channel outer (top+bottom) and middle values.
module g3f_col_cell
  import g3f_pkg::*;
(
  input  logic                          clk,
  input  logic                          shift,
  input  col_t                          col_in,
  output col_t                          col_out,
  output logic [CHAN_N-1:0][CH_W:0]     outer,
  output logic [CHAN_N-1:0][CH_W-1:0]   mid
);

  col_t col;

  // Advance the column on shift
  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

  // Column partial sums per channel
  always_comb begin
    for (int k = 0; k < CHAN_N; k++) begin
      outer[k] = {1'b0, col.top[k]} + {1'b0, col.bot[k]};
      mid[k]   = col.mid[k];
    end
  end

endmodule

>>> src/g3f_chan_mac.sv
// Weighted sum of one channel: registered products, then add, truncate, saturate.
// Uses g3f_pkg.
module g3f_chan_mac
  import g3f_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic [CH_W+1:0]   corner_sum,
  input  logic [CH_W+1:0]   edge_sum,
  input  logic [CH_W-1:0]   center,
  input  weights_t          wgt,
  output logic [CH_W-1:0]   result
);

  localparam int PROD_W = CH_W + 2 + WGT_W;  // 26
  localparam int SUM_W  = PROD_W + 2;        // 28
  localparam int CPRD_W = CH_W + WGT_W;      // 24

  logic [PROD_W-1:0]       corner_prod;
  logic [PROD_W-1:0]       edge_prod;
  logic [CPRD_W-1:0]       center_prod;
  logic [SUM_W-1:0]        sum;
  logic [SUM_W-WGT_W-1:0]  sum_int;

  // Register the three products
  always_ff @(posedge clk) begin
    if (load) begin
      corner_prod <= PROD_W'(corner_sum) * PROD_W'(wgt.corner_wgt);
      edge_prod   <= PROD_W'(edge_sum) * PROD_W'(wgt.edge_wgt);
      center_prod <= CPRD_W'(center) * CPRD_W'(wgt.center_wgt);
    end
  end

  // Add, drop the fraction, clamp to 255
  always_comb begin
    sum     = SUM_W'(corner_prod) + SUM_W'(edge_prod) + SUM_W'(center_prod);
    sum_int = sum[SUM_W-1:WGT_W];
    if (sum_int > (SUM_W-WGT_W)'({CH_W{1'b1}})) begin
      result = {CH_W{1'b1}};
    end else begin
      result = sum_int[CH_W-1:0];
    end
  end

endmodule

>>> src/gaussian_3x3_rgba_filter_core.sv
// Channel   Handshake            Payload
// in        in_valid / in_stall  red_in, green_in, blue_in, alpha_in
// out       out_valid/out_stall  out_row, out_col, red/green/blue/alpha_out, frame_last
// cfg       cfg_write            cfg_index, cfg_data (no read-back)
//
// One pixel per clock sustained while out_stall is low. A result passes the line store
// read, the window shift and the product registers; its sum goes into the output
// register. Border pixels give no result and leave a bubble that later stages absorb.
// rst is synchronous; it clears counters and stage valids and sets config registers to
// reset values. The line store is not cleared. Output stall backs up through the stages.
// Top level of the 3x3 RGBA blur; uses g3f_pkg, g3f_line_store, g3f_col_cell,
// g3f_chan_mac and assert_macros.svh.
`include "assert_macros.svh"

module gaussian_3x3_rgba_filter_core
  import g3f_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  // config
  input  logic              cfg_write,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // input pixels
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CH_W-1:0]   red_in,
  input  logic [CH_W-1:0]   green_in,
  input  logic [CH_W-1:0]   blue_in,
  input  logic [CH_W-1:0]   alpha_in,
  // filtered pixels
  output logic              out_valid,
  input  logic              out_stall,
  output logic [POS_W-1:0]  out_row,
  output logic [POS_W-1:0]  out_col,
  output logic [CH_W-1:0]   red_out,
  output logic [CH_W-1:0]   green_out,
  output logic [CH_W-1:0]   blue_out,
  output logic [CH_W-1:0]   alpha_out,
  output logic              frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = RW + 1;

  // Config registers
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  weights_t          wgt;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_WIDTH;
      image_height   <= RST_HEIGHT;
      wgt.corner_wgt <= RST_CORNER;
      wgt.edge_wgt   <= RST_EDGE;
      wgt.center_wgt <= RST_CENTER;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width    <= cfg_data[SIZE_W-1:0];
        CFG_IMAGE_HEIGHT:  image_height   <= cfg_data[SIZE_W-1:0];
        CFG_CORNER_WEIGHT: wgt.corner_wgt <= cfg_data[WGT_W-1:0];
        CFG_EDGE_WEIGHT:   wgt.edge_wgt   <= cfg_data[WGT_W-1:0];
        CFG_CENTER_WEIGHT: wgt.center_wgt <= cfg_data[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size to 3..MAX
  logic [31:0]   width_ext;
  logic [31:0]   height_ext;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    width_ext  = 32'(image_width);
    height_ext = 32'(image_height);
    if (width_ext < 32'd3) begin
      w_eff = WW'(3);
    end else if (width_ext > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_ext);
    end
    if (height_ext < 32'd3) begin
      h_eff = HW'(3);
    end else if (height_ext > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_ext);
    end
  end

  // Stage handshakes
  logic v1, v2, v3;
  logic r1, r2, r3, out_ready;
  logic accept;
  logic load2;

  assign out_ready = !out_valid || !out_stall;
  assign r3        = !v3 || out_ready;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign in_stall  = !r1;
  assign accept    = in_valid && r1;
  assign load2     = v1 && r2;

  // Raster position of the next pixel
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  tag_t          tag_in;

  assign col_inc = WW'(col_count) + WW'(1);
  assign row_inc = HW'(row_count) + HW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_inc >= w_eff) begin
        col_count <= '0;
        if (row_inc >= h_eff) begin
          row_count <= '0;
        end else begin
          row_count <= row_inc[RW-1:0];
        end
      end else begin
        col_count <= col_inc[CW-1:0];
      end
    end
  end

  // Interior test and tags of the centre pixel
  always_comb begin
    tag_in.res  = (32'(row_count) >= 32'd2) && (32'(col_count) >= 32'd2) &&
                  (HW'(row_count) < h_eff) && (WW'(col_count) < w_eff);
    tag_in.row  = POS_W'(32'(row_count) - 32'd1);
    tag_in.col  = POS_W'(32'(col_count) - 32'd1);
    tag_in.last = (HW'(row_count) == h_eff - HW'(1)) &&
                  (WW'(col_count) == w_eff - WW'(1));
  end

  // Stage 1: line store read
  pixel_t        px_in;
  pixel_t        px1;
  logic [CW-1:0] addr1;
  tag_t          tag1;
  line_entry_t   rd_data;
  line_entry_t   wr_data;

  assign px_in = {alpha_in, blue_in, green_in, red_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px1   <= px_in;
      addr1 <= col_count;
      tag1  <= tag_in;
    end
  end

  // Age the column: new pixel into the upper row, upper row into the oldest
  assign wr_data.above  = px1;
  assign wr_data.above2 = rd_data.above;

  g3f_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (CW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (rd_data),
    .wr_en   (load2),
    .wr_addr (addr1),
    .wr_data (wr_data)
  );

  // Stage 2: window, a chain of three column cells, newest on the right
  col_t                          col_new;
  col_t                          cell_col  [3];
  logic [CHAN_N-1:0][CH_W:0]     cell_outer[3];
  logic [CHAN_N-1:0][CH_W-1:0]   cell_mid  [3];
  tag_t                          tag2;

  assign col_new.top = rd_data.above2;
  assign col_new.mid = rd_data.above;
  assign col_new.bot = px1;

  g3f_col_cell u_cell_2 (
    .clk     (clk),
    .shift   (load2),
    .col_in  (col_new),
    .col_out (cell_col[2]),
    .outer   (cell_outer[2]),
    .mid     (cell_mid[2])
  );

  g3f_col_cell u_cell_1 (
    .clk     (clk),
    .shift   (load2),
    .col_in  (cell_col[2]),
    .col_out (cell_col[1]),
    .outer   (cell_outer[1]),
    .mid     (cell_mid[1])
  );

  g3f_col_cell u_cell_0 (
    .clk     (clk),
    .shift   (load2),
    .col_in  (cell_col[1]),
    .col_out (cell_col[0]),
    .outer   (cell_outer[0]),
    .mid     (cell_mid[0])
  );

  // Only interior items travel past the window
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1 && tag1.res;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      tag2 <= tag1;
    end
  end

  // Stage 3: products per channel; stage 4: output register
  logic [CHAN_N-1:0][CH_W+1:0] corner_sum;
  logic [CHAN_N-1:0][CH_W+1:0] edge_sum;
  logic [CHAN_N-1:0][CH_W-1:0] chan_res;
  tag_t                        tag3;

  for (genvar k = 0; k < CHAN_N; k++) begin : g_chan
    assign corner_sum[k] = (CH_W+2)'(cell_outer[0][k]) + (CH_W+2)'(cell_outer[2][k]);
    assign edge_sum[k]   = (CH_W+2)'(cell_mid[0][k]) + (CH_W+2)'(cell_mid[2][k]) +
                           (CH_W+2)'(cell_outer[1][k]);

    g3f_chan_mac u_mac (
      .clk        (clk),
      .load       (r3),
      .corner_sum (corner_sum[k]),
      .edge_sum   (edge_sum[k]),
      .center     (cell_mid[1][k]),
      .wgt        (wgt),
      .result     (chan_res[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      tag3 <= tag2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_row    <= tag3.row;
      out_col    <= tag3.col;
      red_out    <= chan_res[0];
      green_out  <= chan_res[1];
      blue_out   <= chan_res[2];
      alpha_out  <= chan_res[3];
      frame_last <= tag3.last;
    end
  end

  // Checks
  `G3F_ASSERT_NXT(a_col_wrap, accept && (col_inc >= w_eff), col_count == '0,
    "column counter did not wrap at row end")
  `G3F_ASSERT_NXT(a_stage2_hold, v2 && !r3, v2 && $stable(tag2),
    "stalled window result lost or changed")
  `G3F_ASSERT_IMP(a_interior_tag, out_valid, (out_row != '0) && (out_col != '0),
    "border pixel tagged as result")
  `G3F_ASSERT_IMP(a_last_col, out_valid && frame_last,
    out_col == POS_W'(32'(w_eff) - 32'd2), "frame end flagged off the last column")

endmodule
